>>> sv/mhtq_pkg.sv
`timescale 1ns / 1ps
// Package for the min-heap timer queue: sizes, command and result codes, heap entry type.
// Used by min_heap_timer_queue_unit; depends on nothing else.
package mhtq_pkg;

    localparam int CAPACITY     = 32;
    localparam int HANDLE_COUNT = 256;
    localparam int IDX_W        = $clog2(CAPACITY);
    localparam int CNT_W        = $clog2(CAPACITY + 1);
    localparam int TIME_W       = 32;
    localparam int HANDLE_W     = 8;
    localparam int MARK_W       = $clog2(HANDLE_COUNT);

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_CANCEL = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;

    localparam logic [1:0] KIND_ADD_ACK    = 2'd0;
    localparam logic [1:0] KIND_CANCEL_ACK = 2'd1;
    localparam logic [1:0] KIND_FIRED      = 2'd2;
    localparam logic [1:0] KIND_TICK_DONE  = 2'd3;

    typedef struct packed {
        logic [TIME_W-1:0]   expiry;
        logic [HANDLE_W-1:0] owner;
    } t_entry;

endpackage

>>> sv/min_heap_timer_queue_unit.sv
`timescale 1ns / 1ps
// Top level of the min-heap timer queue: control sequencer, heap memory and cancel marks.
// Depends on mhtq_pkg.
//
// Usage: an input word (i_valid/o_ready) carries a command: add a timer, cancel a
// handle, or tick with the current time. Result words leave on o_valid/i_ready.
// An add or cancel gives one result; a tick gives one word per timer fired, the last
// flagged, or a single tick-done word when nothing fires.
// One input word is worked on at a time; o_ready is high only between commands.
// An add climbs from the new leaf, comparing it with each parent in turn until the parent
// is not later; a tick pops each due entry from the root and sifts the last entry down,
// one level at a time. The heap and mark memories return their reads from a register,
// so each level costs a read and a compare.
// A fired word is held back until the next one is known, so that the final one can
// carry the last flag. A result waits in the output register while the receiver
// stalls; the sequencer only stops when it must place a further word there.
// Reset empties the heap and then clears the cancel marks one per cycle, so o_ready
// stays low after reset until all 256 marks are clear, before the first word is taken.
module min_heap_timer_queue_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_command,
    input  logic [mhtq_pkg::TIME_W-1:0]   i_expire_time,
    input  logic [mhtq_pkg::HANDLE_W-1:0] i_handle,
    input  logic [mhtq_pkg::TIME_W-1:0]   i_now_time,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [1:0]                    o_kind,
    output logic                          o_status,
    output logic [mhtq_pkg::HANDLE_W-1:0] o_fired_handle,
    output logic                          o_last
);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_UP_RD, S_UP_CMP, S_T_RD, S_T_CHK, S_T_MARK, S_DN_RD, S_DN_CMP,
        S_T_END, S_EMIT
    } t_state;

    // Heap memory with two read ports and one write port.
    mhtq_pkg::t_entry r_mem [mhtq_pkg::CAPACITY];
    mhtq_pkg::t_entry r_rd_a, r_rd_b;
    logic                       mem_we, mem_re;
    logic [mhtq_pkg::IDX_W-1:0] mem_wa, mem_ra_a, mem_ra_b;
    mhtq_pkg::t_entry           mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_a <= r_mem[mem_ra_a];
            r_rd_b <= r_mem[mem_ra_b];
        end
    end

    // Cancel marks, one bit per handle, with one read port and one write port.
    logic                        r_marks [mhtq_pkg::HANDLE_COUNT];
    logic                        r_mark_rd;
    logic                        mark_we, mark_re, mark_wd;
    logic [mhtq_pkg::MARK_W-1:0] mark_wa, mark_ra;

    always_ff @(posedge i_clk) begin
        if (mark_we) begin
            r_marks[mark_wa] <= mark_wd;
        end
        if (mark_re) begin
            r_mark_rd <= r_marks[mark_ra];
        end
    end

    t_state                          r_state, n_state;
    logic [mhtq_pkg::MARK_W-1:0]     r_clr_idx, n_clr_idx;
    logic [mhtq_pkg::CNT_W-1:0]      r_count, n_count;
    logic [mhtq_pkg::IDX_W-1:0]      r_pos, n_pos;
    mhtq_pkg::t_entry                r_cur, n_cur;
    logic [mhtq_pkg::TIME_W-1:0]     r_now, n_now;
    logic                            r_pend, n_pend;
    logic [mhtq_pkg::HANDLE_W-1:0]   r_pend_h, n_pend_h;
    logic [1:0]                      r_res_kind, n_res_kind;
    logic                            r_res_status, n_res_status;
    logic                            r_ovalid, n_ovalid;
    logic [1:0]                      r_okind, n_okind;
    logic                            r_ostatus, n_ostatus;
    logic [mhtq_pkg::HANDLE_W-1:0]   r_ohandle, n_ohandle;
    logic                            r_olast, n_olast;

    logic                            out_free;
    logic [mhtq_pkg::IDX_W-1:0]      parent;
    logic [mhtq_pkg::CNT_W:0]        child_l;
    logic [mhtq_pkg::CNT_W:0]        child_r;
    logic                            take_r;
    mhtq_pkg::t_entry                best;
    logic [mhtq_pkg::IDX_W-1:0]      best_idx;

    assign out_free = !r_ovalid || i_ready;
    assign parent   = (r_pos - mhtq_pkg::IDX_W'(1)) >> 1;
    assign child_l  = (mhtq_pkg::CNT_W + 1)'({r_pos, 1'b1});
    assign child_r  = child_l + (mhtq_pkg::CNT_W + 1)'(1);
    assign take_r   = (child_r < (mhtq_pkg::CNT_W + 1)'(r_count))
                      && (r_rd_b.expiry < r_rd_a.expiry);
    assign best     = take_r ? r_rd_b : r_rd_a;
    assign best_idx = take_r ? child_r[mhtq_pkg::IDX_W-1:0] : child_l[mhtq_pkg::IDX_W-1:0];

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_ovalid;
    assign o_kind         = r_okind;
    assign o_status       = r_ostatus;
    assign o_fired_handle = r_ohandle;
    assign o_last         = r_olast;

    always_comb begin
        n_state      = r_state;
        n_clr_idx    = r_clr_idx;
        n_count      = r_count;
        n_pos        = r_pos;
        n_cur        = r_cur;
        n_now        = r_now;
        n_pend       = r_pend;
        n_pend_h     = r_pend_h;
        n_res_kind   = r_res_kind;
        n_res_status = r_res_status;
        n_ovalid     = r_ovalid && !i_ready;
        n_okind      = r_okind;
        n_ostatus    = r_ostatus;
        n_ohandle    = r_ohandle;
        n_olast      = r_olast;
        mem_we       = 1'b0;
        mem_wa       = r_pos;
        mem_wd       = r_cur;
        mem_re       = 1'b0;
        mem_ra_a     = '0;
        mem_ra_b     = '0;
        mark_we      = 1'b0;
        mark_wa      = i_handle[mhtq_pkg::MARK_W-1:0];
        mark_wd      = 1'b0;
        mark_re      = 1'b0;
        mark_ra      = r_rd_a.owner[mhtq_pkg::MARK_W-1:0];

        unique case (r_state)
            S_CLR: begin
                mark_we   = 1'b1;
                mark_wa   = r_clr_idx;
                n_clr_idx = r_clr_idx + mhtq_pkg::MARK_W'(1);
                if (r_clr_idx == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_res_status = 1'b0;
                    case (i_command)
                        mhtq_pkg::CMD_ADD: begin
                            n_res_kind = mhtq_pkg::KIND_ADD_ACK;
                            if (r_count == mhtq_pkg::CNT_W'(mhtq_pkg::CAPACITY)) begin
                                n_res_status = 1'b1;
                                n_state      = S_EMIT;
                            end else begin
                                mark_we = 1'b1;
                                n_count = r_count + mhtq_pkg::CNT_W'(1);
                                n_pos   = r_count[mhtq_pkg::IDX_W-1:0];
                                n_cur   = '{expiry: i_expire_time, owner: i_handle};
                                n_state = S_UP_RD;
                            end
                        end
                        mhtq_pkg::CMD_CANCEL: begin
                            mark_we    = 1'b1;
                            mark_wd    = 1'b1;
                            n_res_kind = mhtq_pkg::KIND_CANCEL_ACK;
                            n_state    = S_EMIT;
                        end
                        mhtq_pkg::CMD_TICK: begin
                            n_now   = i_now_time;
                            n_pend  = 1'b0;
                            n_state = S_T_RD;
                        end
                        default: ;
                    endcase
                end
            end
            S_UP_RD: begin
                if (r_pos == '0) begin
                    mem_we  = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    mem_re   = 1'b1;
                    mem_ra_a = parent;
                    n_state  = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                mem_we = 1'b1;
                if (r_rd_a.expiry <= r_cur.expiry) begin
                    n_state = S_EMIT;
                end else begin
                    mem_wd  = r_rd_a;
                    n_pos   = parent;
                    n_state = S_UP_RD;
                end
            end
            S_T_RD: begin
                if (r_count == '0) begin
                    n_state = S_T_END;
                end else begin
                    mem_re  = 1'b1;
                    n_state = S_T_CHK;
                end
            end
            S_T_CHK: begin
                if (r_rd_a.expiry > r_now) begin
                    n_state = S_T_END;
                end else begin
                    // The popped root is kept while its mark and the last entry are read.
                    mark_re  = 1'b1;
                    n_cur    = r_rd_a;
                    n_count  = r_count - mhtq_pkg::CNT_W'(1);
                    mem_re   = 1'b1;
                    mem_ra_a = n_count[mhtq_pkg::IDX_W-1:0];
                    n_state  = S_T_MARK;
                end
            end
            S_T_MARK: begin
                if (!r_mark_rd && r_pend && !out_free) begin
                    // Wait for room to pass on the word held back.
                    n_state = S_T_MARK;
                end else begin
                    if (!r_mark_rd) begin
                        if (r_pend) begin
                            n_ovalid  = 1'b1;
                            n_okind   = mhtq_pkg::KIND_FIRED;
                            n_ostatus = 1'b0;
                            n_ohandle = r_pend_h;
                            n_olast   = 1'b0;
                        end
                        n_pend   = 1'b1;
                        n_pend_h = r_cur.owner;
                    end
                    n_cur = r_rd_a;
                    n_pos = '0;
                    if (r_count == '0) begin
                        n_state = S_T_RD;
                    end else begin
                        n_state = S_DN_RD;
                    end
                end
            end
            S_DN_RD: begin
                if (child_l >= (mhtq_pkg::CNT_W + 1)'(r_count)) begin
                    mem_we  = 1'b1;
                    n_state = S_T_RD;
                end else begin
                    mem_re   = 1'b1;
                    mem_ra_a = child_l[mhtq_pkg::IDX_W-1:0];
                    mem_ra_b = child_r[mhtq_pkg::IDX_W-1:0];
                    n_state  = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                mem_we = 1'b1;
                if (best.expiry < r_cur.expiry) begin
                    mem_wd  = best;
                    n_pos   = best_idx;
                    n_state = S_DN_RD;
                end else begin
                    n_state = S_T_RD;
                end
            end
            S_T_END: begin
                if (out_free) begin
                    n_ovalid  = 1'b1;
                    n_okind   = r_pend ? mhtq_pkg::KIND_FIRED : mhtq_pkg::KIND_TICK_DONE;
                    n_ostatus = 1'b0;
                    n_ohandle = r_pend ? r_pend_h : '0;
                    n_olast   = 1'b1;
                    n_pend    = 1'b0;
                    n_state   = S_IDLE;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_ovalid  = 1'b1;
                    n_okind   = r_res_kind;
                    n_ostatus = r_res_status;
                    n_ohandle = '0;
                    n_olast   = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr_idx <= '0;
            r_count   <= '0;
            r_pend    <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
            r_count   <= n_count;
            r_pend    <= n_pend;
            r_ovalid  <= n_ovalid;
        end
        r_pos        <= n_pos;
        r_cur        <= n_cur;
        r_now        <= n_now;
        r_pend_h     <= n_pend_h;
        r_res_kind   <= n_res_kind;
        r_res_status <= n_res_status;
        r_okind      <= n_okind;
        r_ostatus    <= n_ostatus;
        r_ohandle    <= n_ohandle;
        r_olast      <= n_olast;
    end

endmodule
